/* hdl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths and codes for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  localparam int QW       = 32;  // Q16.16 word
  localparam int QFRAC    = 16;  // fraction bits
  localparam int AXW      = 18;  // unit axis component, signed
  localparam int UW       = 20;  // true-up axis component, signed
  localparam int SQW      = 30;  // normalized magnitude width
  localparam int LENW     = 31;  // vector length width
  localparam int QBITS    = 17;  // quotient bits of one axis component
  localparam int NORM_MSB = 29;  // target msb of the largest magnitude

  localparam logic [QW-1:0] Q_ONE = 32'h0001_0000;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

endpackage

`default_nettype wire

/* hdl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix builder, signed Q16.16, one row per result.
// ----------------------------------------------------------------------------
// Each accepted request (eye, target, up) produces four results, rows 0 to 3
// in order, the last marked by out_tlast. The pipeline takes a new request in
// any cycle in which it is not stalled; the output register presents the four
// rows of a matrix one per cycle while out_tready is high, and a new matrix
// loads only when it is empty or as the last row of the previous one is taken.
// Requests keep entering while a finished matrix waits until the last pipeline
// stage holds one. out_tuser[0] flags a zero-length forward or right axis,
// out_tuser[1] a clipped translation entry.
`default_nettype none

module look_at_view_matrix
  import lav_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index, col0, col1, col2, col3, zero pad
  output logic [135:0] out_tdata,
  output logic         out_tlast,
  // degenerate, saturated
  output logic [1:0]   out_tuser
);

  localparam int DFW  = QW + 1;
  localparam int CPW  = QW + AXW;
  localparam int RRW  = CPW + 1;
  localparam int UPW  = 2 * AXW;
  localparam int URW  = UPW + 1;
  localparam int DPW  = UW + QW;
  localparam int DSW  = DPW + 2;
  localparam int TW   = DSW + 1;
  localparam int TQW  = TW - QFRAC;
  localparam int SW1  = 6 * QW;
  localparam int SW2  = 3 * QW + 3 * AXW + 1;

  logic en;

  // input stage
  logic [2:0][DFW-1:0] s0_diff_nxt;
  logic                s0_v_r;
  logic [2:0][DFW-1:0] s0_diff_r;
  logic [2:0][QW-1:0]  s0_eye_r;
  logic [2:0][QW-1:0]  s0_up_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s0_diff_nxt[i] = {in_tdata[QW*(3+i)+QW-1], in_tdata[QW*(3+i) +: QW]}
                     - {in_tdata[QW*i+QW-1], in_tdata[QW*i +: QW]};
    end
  end

  // forward axis
  logic                n1_v;
  logic [2:0][AXW-1:0] n1_f;
  logic                n1_zero;
  logic [SW1-1:0]      n1_sb;

  lav_norm #(.W(DFW), .SW(SW1)) u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_vec    (s0_diff_r),
    .in_sb     ({s0_up_r, s0_eye_r}),
    .out_valid (n1_v),
    .out_vec   (n1_f),
    .out_zero  (n1_zero),
    .out_sb    (n1_sb)
  );

  logic [2:0][QW-1:0] n1_eye;
  logic [2:0][QW-1:0] n1_up;
  assign n1_eye = n1_sb[3*QW-1:0];
  assign n1_up  = n1_sb[6*QW-1:3*QW];

  // up cross forward
  logic [5:0][CPW-1:0] c1_p_nxt;
  logic                c1_v_r;
  logic [5:0][CPW-1:0] c1_p_r;
  logic [2:0][QW-1:0]  c1_eye_r;
  logic [2:0][AXW-1:0] c1_f_r;
  logic                c1_degen_r;

  always_comb begin
    c1_p_nxt[0] = $signed(n1_up[1]) * $signed(n1_f[2]);
    c1_p_nxt[1] = $signed(n1_up[2]) * $signed(n1_f[1]);
    c1_p_nxt[2] = $signed(n1_up[2]) * $signed(n1_f[0]);
    c1_p_nxt[3] = $signed(n1_up[0]) * $signed(n1_f[2]);
    c1_p_nxt[4] = $signed(n1_up[0]) * $signed(n1_f[1]);
    c1_p_nxt[5] = $signed(n1_up[1]) * $signed(n1_f[0]);
  end

  logic [2:0][RRW-1:0] c2_rr_nxt;
  logic                c2_v_r;
  logic [2:0][RRW-1:0] c2_rr_r;
  logic [2:0][QW-1:0]  c2_eye_r;
  logic [2:0][AXW-1:0] c2_f_r;
  logic                c2_degen_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2_rr_nxt[i] = {c1_p_r[2*i][CPW-1], c1_p_r[2*i]}
                   - {c1_p_r[2*i+1][CPW-1], c1_p_r[2*i+1]};
    end
  end

  // right axis
  logic                n2_v;
  logic [2:0][AXW-1:0] n2_r;
  logic                n2_zero;
  logic [SW2-1:0]      n2_sb;

  lav_norm #(.W(RRW), .SW(SW2)) u_norm_rgt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c2_v_r),
    .in_vec    (c2_rr_r),
    .in_sb     ({c2_degen_r, c2_f_r, c2_eye_r}),
    .out_valid (n2_v),
    .out_vec   (n2_r),
    .out_zero  (n2_zero),
    .out_sb    (n2_sb)
  );

  logic [2:0][QW-1:0]  n2_eye;
  logic [2:0][AXW-1:0] n2_f;
  logic                n2_degen;
  assign n2_eye   = n2_sb[3*QW-1:0];
  assign n2_f     = n2_sb[3*QW+3*AXW-1:3*QW];
  assign n2_degen = n2_sb[SW2-1];

  // forward cross right
  logic [5:0][UPW-1:0] u1_p_nxt;
  logic                u1_v_r;
  logic [5:0][UPW-1:0] u1_p_r;
  logic [2:0][QW-1:0]  u1_eye_r;
  logic [2:0][AXW-1:0] u1_f_r;
  logic [2:0][AXW-1:0] u1_r_r;
  logic                u1_degen_r;

  always_comb begin
    u1_p_nxt[0] = $signed(n2_f[1]) * $signed(n2_r[2]);
    u1_p_nxt[1] = $signed(n2_f[2]) * $signed(n2_r[1]);
    u1_p_nxt[2] = $signed(n2_f[2]) * $signed(n2_r[0]);
    u1_p_nxt[3] = $signed(n2_f[0]) * $signed(n2_r[2]);
    u1_p_nxt[4] = $signed(n2_f[0]) * $signed(n2_r[1]);
    u1_p_nxt[5] = $signed(n2_f[1]) * $signed(n2_r[0]);
  end

  logic [2:0][URW-1:0] u2_raw;
  logic [2:0][URW-1:0] u2_bias;
  logic [2:0][UW-1:0]  u2_u_nxt;
  logic                u2_v_r;
  logic [2:0][UW-1:0]  u2_u_r;
  logic [2:0][QW-1:0]  u2_eye_r;
  logic [2:0][AXW-1:0] u2_f_r;
  logic [2:0][AXW-1:0] u2_r_r;
  logic                u2_degen_r;

  // divide by one, rounding toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u2_raw[i]   = {u1_p_r[2*i][UPW-1], u1_p_r[2*i]}
                  - {u1_p_r[2*i+1][UPW-1], u1_p_r[2*i+1]};
      u2_bias[i]  = u2_raw[i] + (u2_raw[i][URW-1] ? URW'(16'hFFFF) : URW'(0));
      u2_u_nxt[i] = u2_bias[i][QFRAC +: UW];
    end
  end

  // axis dot eye
  logic [2:0][2:0][DPW-1:0] d1_p_nxt;
  logic                     d1_v_r;
  logic [2:0][2:0][DPW-1:0] d1_p_r;
  logic [2:0][AXW-1:0]      d1_r_r;
  logic [2:0][UW-1:0]       d1_u_r;
  logic [2:0][AXW-1:0]      d1_f_r;
  logic                     d1_degen_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_p_nxt[0][i] = $signed(u2_r_r[i]) * $signed(u2_eye_r[i]);
      d1_p_nxt[1][i] = $signed(u2_u_r[i]) * $signed(u2_eye_r[i]);
      d1_p_nxt[2][i] = $signed(u2_f_r[i]) * $signed(u2_eye_r[i]);
    end
  end

  logic [2:0][DSW-1:0] d2_s_nxt;
  logic                d2_v_r;
  logic [2:0][DSW-1:0] d2_s_r;
  logic [2:0][AXW-1:0] d2_r_r;
  logic [2:0][UW-1:0]  d2_u_r;
  logic [2:0][AXW-1:0] d2_f_r;
  logic                d2_degen_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d2_s_nxt[k] = {{2{d1_p_r[k][0][DPW-1]}}, d1_p_r[k][0]}
                  + {{2{d1_p_r[k][1][DPW-1]}}, d1_p_r[k][1]}
                  + {{2{d1_p_r[k][2][DPW-1]}}, d1_p_r[k][2]};
    end
  end

  // negate, scale and clamp the translation
  logic [2:0][TW-1:0]  d3_neg;
  logic [2:0][TW-1:0]  d3_bias;
  logic [2:0][TQW-1:0] d3_t;
  logic [2:0]          d3_ovf;
  logic [2:0][QW-1:0]  d3_tr_nxt;
  logic                d3_v_r;
  logic [2:0][QW-1:0]  d3_tr_r;
  logic                d3_sat_r;
  logic [2:0][AXW-1:0] d3_r_r;
  logic [2:0][UW-1:0]  d3_u_r;
  logic [2:0][AXW-1:0] d3_f_r;
  logic                d3_degen_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d3_neg[k]  = -{d2_s_r[k][DSW-1], d2_s_r[k]};
      d3_bias[k] = d3_neg[k] + (d3_neg[k][TW-1] ? TW'(16'hFFFF) : TW'(0));
      d3_t[k]    = d3_bias[k][TW-1:QFRAC];
      d3_ovf[k]  = !((&d3_t[k][TQW-1:QW-1]) || !(|d3_t[k][TQW-1:QW-1]));
      if (d3_ovf[k]) begin
        d3_tr_nxt[k] = d3_t[k][TQW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
        d3_tr_nxt[k] = d3_t[k][QW-1:0];
      end
    end
  end

  // output register, four rows per matrix
  logic                hold_v_r;
  logic                hold_v_nxt;
  logic [1:0]          row_r;
  logic [1:0]          row_nxt;
  logic                hold_free;
  logic [2:0][QW-1:0]  hd_tr_r;
  logic [2:0][AXW-1:0] hd_r_r;
  logic [2:0][UW-1:0]  hd_u_r;
  logic [2:0][AXW-1:0] hd_f_r;
  logic                hd_degen_r;
  logic                hd_sat_r;

  assign hold_free = !hold_v_r || (out_tready && (row_r == ROW_LAST));
  assign en        = !d3_v_r || hold_free;
  assign in_tready = en;

  always_comb begin
    hold_v_nxt = hold_v_r;
    row_nxt    = row_r;
    if (hold_v_r && out_tready) begin
      if (row_r == ROW_LAST) begin
        hold_v_nxt = 1'b0;
      end else begin
        row_nxt = row_r + 2'd1;
      end
    end
    if (en && d3_v_r) begin
      hold_v_nxt = 1'b1;
      row_nxt    = ROW_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      c1_v_r   <= 1'b0;
      c2_v_r   <= 1'b0;
      u1_v_r   <= 1'b0;
      u2_v_r   <= 1'b0;
      d1_v_r   <= 1'b0;
      d2_v_r   <= 1'b0;
      d3_v_r   <= 1'b0;
      hold_v_r <= 1'b0;
      row_r    <= ROW_RIGHT;
    end else begin
      hold_v_r <= hold_v_nxt;
      row_r    <= row_nxt;
      if (en) begin
        s0_v_r <= in_tvalid;
        c1_v_r <= n1_v;
        c2_v_r <= c1_v_r;
        u1_v_r <= n2_v;
        u2_v_r <= u1_v_r;
        d1_v_r <= u2_v_r;
        d2_v_r <= d1_v_r;
        d3_v_r <= d2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_diff_r  <= s0_diff_nxt;
      s0_eye_r   <= in_tdata[3*QW-1:0];
      s0_up_r    <= in_tdata[9*QW-1:6*QW];
      c1_p_r     <= c1_p_nxt;
      c1_eye_r   <= n1_eye;
      c1_f_r     <= n1_f;
      c1_degen_r <= n1_zero;
      c2_rr_r    <= c2_rr_nxt;
      c2_eye_r   <= c1_eye_r;
      c2_f_r     <= c1_f_r;
      c2_degen_r <= c1_degen_r;
      u1_p_r     <= u1_p_nxt;
      u1_eye_r   <= n2_eye;
      u1_f_r     <= n2_f;
      u1_r_r     <= n2_r;
      u1_degen_r <= n2_degen | n2_zero;
      u2_u_r     <= u2_u_nxt;
      u2_eye_r   <= u1_eye_r;
      u2_f_r     <= u1_f_r;
      u2_r_r     <= u1_r_r;
      u2_degen_r <= u1_degen_r;
      d1_p_r     <= d1_p_nxt;
      d1_r_r     <= u2_r_r;
      d1_u_r     <= u2_u_r;
      d1_f_r     <= u2_f_r;
      d1_degen_r <= u2_degen_r;
      d2_s_r     <= d2_s_nxt;
      d2_r_r     <= d1_r_r;
      d2_u_r     <= d1_u_r;
      d2_f_r     <= d1_f_r;
      d2_degen_r <= d1_degen_r;
      d3_tr_r    <= d3_tr_nxt;
      d3_sat_r   <= |d3_ovf;
      d3_r_r     <= d2_r_r;
      d3_u_r     <= d2_u_r;
      d3_f_r     <= d2_f_r;
      d3_degen_r <= d2_degen_r;
    end
    if (en && d3_v_r) begin
      hd_tr_r    <= d3_tr_r;
      hd_r_r     <= d3_r_r;
      hd_u_r     <= d3_u_r;
      hd_f_r     <= d3_f_r;
      hd_degen_r <= d3_degen_r;
      hd_sat_r   <= d3_sat_r;
    end
  end

  // row select
  logic [2:0][QW-1:0] col;
  logic [QW-1:0]      col3;

  always_comb begin
    case (row_r)
      ROW_RIGHT: begin
        for (int i = 0; i < 3; i++) col[i] = {{(QW-AXW){hd_r_r[i][AXW-1]}}, hd_r_r[i]};
        col3 = hd_tr_r[0];
      end
      ROW_UP: begin
        for (int i = 0; i < 3; i++) col[i] = {{(QW-UW){hd_u_r[i][UW-1]}}, hd_u_r[i]};
        col3 = hd_tr_r[1];
      end
      ROW_FWD: begin
        for (int i = 0; i < 3; i++) col[i] = {{(QW-AXW){hd_f_r[i][AXW-1]}}, hd_f_r[i]};
        col3 = hd_tr_r[2];
      end
      default: begin
        col  = '0;
        col3 = Q_ONE;
      end
    endcase
  end

  assign out_tvalid = hold_v_r;
  assign out_tdata  = {6'b0, col3, col[2], col[1], col[0], row_r};
  assign out_tlast  = (row_r == ROW_LAST);
  assign out_tuser  = {hd_sat_r, hd_degen_r};

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (en && d3_v_r) |-> (!hold_v_r || (out_tready && (row_r == ROW_LAST))))
    else $error("matrix loaded over rows not yet delivered");

  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && out_tready && (row_r != ROW_LAST))
      |=> (hold_v_r && (row_r == $past(row_r) + 2'd1)))
    else $error("row did not advance after a taken row");

  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && !out_tready) |=> (hold_v_r && $stable(row_r)))
    else $error("row changed while stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && out_tready && (row_r == ROW_LAST) && !d3_v_r) |=> !hold_v_r)
    else $error("output still valid after last row with no matrix pending");

endmodule

`default_nettype wire

/* hdl/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: magnitude scaling, squared length,
// bit-per-stage square root and bit-per-stage division of each component.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm
  import lav_pkg::*;
#(
  parameter int W  = 33,
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0][W-1:0]        in_vec,
  input  logic [SW-1:0]            in_sb,
  output logic                     out_valid,
  output logic [2:0][AXW-1:0]      out_vec,
  output logic                     out_zero,
  output logic [SW-1:0]            out_sb
);

  localparam int PW   = $clog2(W);
  localparam int SUMW = 2 * SQW + 2;
  localparam int DW   = SQW + QFRAC + 1;
  localparam logic [PW-1:0] MSBP = PW'(NORM_MSB);

  function automatic logic [PW-1:0] msb_pos(input logic [W-1:0] x);
    logic [PW-1:0] pos;
    pos = '0;
    for (int k = 0; k < W; k++) begin
      if (x[k]) pos = PW'(k);
    end
    return pos;
  endfunction

  // stage 0: magnitudes and maximum
  logic [2:0][W-1:0] n0_a_nxt;
  logic [2:0]        n0_neg_nxt;
  logic [W-1:0]      n0_m_nxt;
  logic              n0_v_r;
  logic [2:0][W-1:0] n0_a_r;
  logic [2:0]        n0_neg_r;
  logic [W-1:0]      n0_m_r;
  logic [SW-1:0]     n0_sb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n0_neg_nxt[i] = in_vec[i][W-1];
      n0_a_nxt[i]   = n0_neg_nxt[i] ? (~in_vec[i] + W'(1)) : in_vec[i];
    end
    n0_m_nxt = n0_a_nxt[0];
    if (n0_a_nxt[1] > n0_m_nxt) n0_m_nxt = n0_a_nxt[1];
    if (n0_a_nxt[2] > n0_m_nxt) n0_m_nxt = n0_a_nxt[2];
  end

  // stage 1: leading bit of the maximum
  logic              n1_v_r;
  logic [2:0][W-1:0] n1_a_r;
  logic [2:0]        n1_neg_r;
  logic [PW-1:0]     n1_p_r;
  logic              n1_zero_r;
  logic [SW-1:0]     n1_sb_r;

  // stage 2: scaled magnitudes
  logic [2:0][SQW-1:0] n2_s_nxt;
  logic                n2_v_r;
  logic [2:0][SQW-1:0] n2_s_r;
  logic [2:0]          n2_neg_r;
  logic                n2_zero_r;
  logic [SW-1:0]       n2_sb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (n1_p_r >= MSBP) begin
        n2_s_nxt[i] = SQW'(n1_a_r[i] >> (n1_p_r - MSBP));
      end else begin
        n2_s_nxt[i] = SQW'({{SQW{1'b0}}, n1_a_r[i]} << (MSBP - n1_p_r));
      end
    end
  end

  // stage 3: squares
  logic [2:0][2*SQW-1:0] n3_sq_nxt;
  logic                  n3_v_r;
  logic [2:0][2*SQW-1:0] n3_sq_r;
  logic [2:0][SQW-1:0]   n3_s_r;
  logic [2:0]            n3_neg_r;
  logic                  n3_zero_r;
  logic [SW-1:0]         n3_sb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n3_sq_nxt[i] = n2_s_r[i] * n2_s_r[i];
    end
  end

  // square root stages, index 0 holds the sum
  logic [SUMW-1:0]     sr_rem_r  [0:LENW];
  logic [LENW-1:0]     sr_root_r [0:LENW];
  logic [2:0][SQW-1:0] sr_s_r    [0:LENW];
  logic [2:0]          sr_neg_r  [0:LENW];
  logic [LENW:0]       sr_zero_r;
  logic [SW-1:0]       sr_sb_r   [0:LENW];
  logic [LENW:0]       sr_v_r;
  logic [SUMW-1:0]     sr_rem_nxt  [1:LENW];
  logic [LENW-1:0]     sr_root_nxt [1:LENW];
  logic [SUMW-1:0]     sr_trial    [1:LENW];
  logic [SUMW-1:0]     sr_sum_nxt;

  assign sr_sum_nxt = SUMW'(n3_sq_r[0]) + SUMW'(n3_sq_r[1]) + SUMW'(n3_sq_r[2]);

  always_comb begin
    for (int k = 0; k < LENW; k++) begin
      sr_trial[k+1] = (SUMW'(sr_root_r[k]) << (LENW - k))
                    | (SUMW'(1) << (2 * (LENW - 1 - k)));
      if (sr_rem_r[k] >= sr_trial[k+1]) begin
        sr_rem_nxt[k+1]  = sr_rem_r[k] - sr_trial[k+1];
        sr_root_nxt[k+1] = sr_root_r[k] | (LENW'(1) << (LENW - 1 - k));
      end else begin
        sr_rem_nxt[k+1]  = sr_rem_r[k];
        sr_root_nxt[k+1] = sr_root_r[k];
      end
    end
  end

  // division stages, index 0 holds the shifted numerators
  logic [2:0][DW-1:0]    dv_rem_r [0:QBITS];
  logic [2:0][QBITS-1:0] dv_q_r   [0:QBITS];
  logic [LENW-1:0]       dv_d_r   [0:QBITS];
  logic [2:0]            dv_neg_r [0:QBITS];
  logic [QBITS:0]        dv_zero_r;
  logic [SW-1:0]         dv_sb_r  [0:QBITS];
  logic [QBITS:0]        dv_v_r;
  logic [2:0][DW-1:0]    dv_rem_nxt [1:QBITS];
  logic [2:0][QBITS-1:0] dv_q_nxt   [1:QBITS];
  logic [DW-1:0]         dv_dd      [1:QBITS];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      dv_dd[k+1] = DW'(dv_d_r[k]) << (QBITS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[k][i] >= dv_dd[k+1]) begin
          dv_rem_nxt[k+1][i] = dv_rem_r[k][i] - dv_dd[k+1];
          dv_q_nxt[k+1][i]   = dv_q_r[k][i] | (QBITS'(1) << (QBITS - 1 - k));
        end else begin
          dv_rem_nxt[k+1][i] = dv_rem_r[k][i];
          dv_q_nxt[k+1][i]   = dv_q_r[k][i];
        end
      end
    end
  end

  // output stage
  logic [2:0][AXW-1:0] o_vec_nxt;
  logic                o_v_r;
  logic [2:0][AXW-1:0] o_vec_r;
  logic                o_zero_r;
  logic [SW-1:0]       o_sb_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[QBITS]) begin
        o_vec_nxt[i] = '0;
      end else if (dv_neg_r[QBITS][i]) begin
        o_vec_nxt[i] = -AXW'(dv_q_r[QBITS][i]);
      end else begin
        o_vec_nxt[i] = AXW'(dv_q_r[QBITS][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_v_r <= 1'b0;
      n1_v_r <= 1'b0;
      n2_v_r <= 1'b0;
      n3_v_r <= 1'b0;
      sr_v_r <= '0;
      dv_v_r <= '0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      n0_v_r <= in_valid;
      n1_v_r <= n0_v_r;
      n2_v_r <= n1_v_r;
      n3_v_r <= n2_v_r;
      sr_v_r <= {sr_v_r[LENW-1:0], n3_v_r};
      dv_v_r <= {dv_v_r[QBITS-1:0], sr_v_r[LENW]};
      o_v_r  <= dv_v_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_a_r    <= n0_a_nxt;
      n0_neg_r  <= n0_neg_nxt;
      n0_m_r    <= n0_m_nxt;
      n0_sb_r   <= in_sb;
      n1_a_r    <= n0_a_r;
      n1_neg_r  <= n0_neg_r;
      n1_p_r    <= msb_pos(n0_m_r);
      n1_zero_r <= (n0_m_r == '0);
      n1_sb_r   <= n0_sb_r;
      n2_s_r    <= n2_s_nxt;
      n2_neg_r  <= n1_neg_r;
      n2_zero_r <= n1_zero_r;
      n2_sb_r   <= n1_sb_r;
      n3_sq_r   <= n3_sq_nxt;
      n3_s_r    <= n2_s_r;
      n3_neg_r  <= n2_neg_r;
      n3_zero_r <= n2_zero_r;
      n3_sb_r   <= n2_sb_r;

      sr_rem_r[0]  <= sr_sum_nxt;
      sr_root_r[0] <= '0;
      sr_s_r[0]    <= n3_s_r;
      sr_neg_r[0]  <= n3_neg_r;
      sr_zero_r[0] <= n3_zero_r;
      sr_sb_r[0]   <= n3_sb_r;
      for (int k = 0; k < LENW; k++) begin
        sr_rem_r[k+1]  <= sr_rem_nxt[k+1];
        sr_root_r[k+1] <= sr_root_nxt[k+1];
        sr_s_r[k+1]    <= sr_s_r[k];
        sr_neg_r[k+1]  <= sr_neg_r[k];
        sr_zero_r[k+1] <= sr_zero_r[k];
        sr_sb_r[k+1]   <= sr_sb_r[k];
      end

      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= DW'({sr_s_r[LENW][i], {QFRAC{1'b0}}});
      end
      dv_q_r[0]    <= '0;
      dv_d_r[0]    <= sr_root_r[LENW];
      dv_neg_r[0]  <= sr_neg_r[LENW];
      dv_zero_r[0] <= sr_zero_r[LENW];
      dv_sb_r[0]   <= sr_sb_r[LENW];
      for (int k = 0; k < QBITS; k++) begin
        dv_rem_r[k+1]  <= dv_rem_nxt[k+1];
        dv_q_r[k+1]    <= dv_q_nxt[k+1];
        dv_d_r[k+1]    <= dv_d_r[k];
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_sb_r[k+1]   <= dv_sb_r[k];
      end

      o_vec_r  <= o_vec_nxt;
      o_zero_r <= dv_zero_r[QBITS];
      o_sb_r   <= dv_sb_r[QBITS];
    end
  end

  assign out_valid = o_v_r;
  assign out_vec   = o_vec_r;
  assign out_zero  = o_zero_r;
  assign out_sb    = o_sb_r;

endmodule

`default_nettype wire
